@@ design/mmpd_pkg.sv @@
package mmpd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_COLUMNS = 4096;

   localparam int INDEX_BITS = 16;
   localparam int COUNT_BITS = 16;
   localparam int PIXEL_BITS = 13;
   localparam int WIDE_BITS = 17;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIXEL_COUNT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_INDEX = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [INDEX_BITS-1:0]         first_index;
      logic signed [SAMPLE_BITS-1:0] first_value;
      logic [INDEX_BITS-1:0]         second_index;
      logic signed [SAMPLE_BITS-1:0] second_value;
      logic                          has_second;
      logic                          window_end;
   } entry_type;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'b01,
      PH_SECOND = 2'b10
   } phase_type;

endpackage

@@ design/mmpd_front.sv @@
module mmpd_front (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic signed [mmpd_pkg::SAMPLE_BITS-1:0]    req_sample_value,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [mmpd_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [mmpd_pkg::CSR_DATA_BITS-1:0]         csr_data,
   output logic                                       push_valid,
   input  logic                                       push_ready,
   output mmpd_pkg::entry_type                        push_entry
);

   localparam logic [mmpd_pkg::WIDE_BITS-1:0] MAX_COL_WIDE =
      mmpd_pkg::WIDE_BITS'(mmpd_pkg::MAX_COLUMNS);

   logic [mmpd_pkg::COUNT_BITS-1:0] point_count_ff;
   logic [mmpd_pkg::PIXEL_BITS-1:0] pixel_count_ff;
   logic [mmpd_pkg::INDEX_BITS-1:0] first_index_ff;

   logic [mmpd_pkg::COUNT_BITS-1:0] sample_ff, sample_in;
   logic [mmpd_pkg::COUNT_BITS-1:0] acc_ff, acc_in;
   logic                            open_ff, open_in;
   logic signed [mmpd_pkg::SAMPLE_BITS-1:0] min_ff, min_in, max_ff, max_in;
   logic [mmpd_pkg::COUNT_BITS-1:0] min_pos_ff, min_pos_in, max_pos_ff, max_pos_in;

   logic [mmpd_pkg::COUNT_BITS-1:0] n;
   logic [mmpd_pkg::WIDE_BITS-1:0]  p_wide;
   logic [mmpd_pkg::COUNT_BITS-1:0] p16;
   logic [mmpd_pkg::COUNT_BITS-1:0] step;
   logic                            decimate;
   logic                            window_end;
   logic                            open_cur;
   logic [mmpd_pkg::COUNT_BITS-1:0] acc_cur;
   logic                            bucket_end;
   logic                            accept;
   logic                            restart;
   logic                            csr_hit;
   logic                            min_first;

   function automatic logic [mmpd_pkg::INDEX_BITS-1:0] sat_index(
      input logic [mmpd_pkg::INDEX_BITS-1:0] base,
      input logic [mmpd_pkg::COUNT_BITS-1:0] rel
   );
      logic [mmpd_pkg::WIDE_BITS-1:0] sum;
      sum = mmpd_pkg::WIDE_BITS'(base) + mmpd_pkg::WIDE_BITS'(rel);
      if (sum[mmpd_pkg::WIDE_BITS-1]) begin
         sat_index = '1;
      end else begin
         sat_index = sum[mmpd_pkg::INDEX_BITS-1:0];
      end
   endfunction

   assign req_ready = push_ready;
   assign csr_ready = 1'b1;
   assign accept = req_valid && req_ready;

   always_comb begin
      unique case (csr_index)
         mmpd_pkg::CSR_POINT_COUNT,
         mmpd_pkg::CSR_PIXEL_COUNT,
         mmpd_pkg::CSR_FIRST_INDEX: csr_hit = 1'b1;
         default:                   csr_hit = 1'b0;
      endcase
   end
   assign restart = csr_valid && csr_ready && csr_hit;

   always_comb begin
      n = (point_count_ff < mmpd_pkg::COUNT_BITS'(2)) ? mmpd_pkg::COUNT_BITS'(2)
                                                      : point_count_ff;
      p_wide = mmpd_pkg::WIDE_BITS'(pixel_count_ff);
      if (p_wide == '0) begin
         p_wide = mmpd_pkg::WIDE_BITS'(1);
      end
      if (p_wide > MAX_COL_WIDE) begin
         p_wide = MAX_COL_WIDE;
      end
      p16 = p_wide[mmpd_pkg::COUNT_BITS-1:0];
      decimate = {3'b000, n} > {1'b0, p_wide, 1'b0};
      step = n - p16;
      window_end = (mmpd_pkg::WIDE_BITS'(sample_ff) + mmpd_pkg::WIDE_BITS'(1))
                   >= mmpd_pkg::WIDE_BITS'(n);
      open_cur = (sample_ff == '0) ? 1'b0 : open_ff;
      acc_cur = (sample_ff == '0) ? step : acc_ff;
      bucket_end = (mmpd_pkg::WIDE_BITS'(acc_cur) < p_wide) || window_end;

      if (!open_cur || (req_sample_value < min_ff)) begin
         min_in = req_sample_value;
         min_pos_in = sample_ff;
      end else begin
         min_in = min_ff;
         min_pos_in = min_pos_ff;
      end
      if (!open_cur || (req_sample_value > max_ff)) begin
         max_in = req_sample_value;
         max_pos_in = sample_ff;
      end else begin
         max_in = max_ff;
         max_pos_in = max_pos_ff;
      end

      acc_in = bucket_end ? (acc_cur + step) : (acc_cur - p16);
      sample_in = window_end ? '0 : (sample_ff + mmpd_pkg::COUNT_BITS'(1));
      open_in = window_end ? 1'b0 : !bucket_end;
      min_first = min_pos_in < max_pos_in;

      push_valid = accept && (!decimate || bucket_end);
      push_entry.window_end = window_end;
      if (!decimate) begin
         push_entry.first_index = sat_index(first_index_ff, sample_ff);
         push_entry.first_value = req_sample_value;
         push_entry.second_index = sat_index(first_index_ff, sample_ff);
         push_entry.second_value = req_sample_value;
         push_entry.has_second = 1'b0;
      end else if (min_first) begin
         push_entry.first_index = sat_index(first_index_ff, min_pos_in);
         push_entry.first_value = min_in;
         push_entry.second_index = sat_index(first_index_ff, max_pos_in);
         push_entry.second_value = max_in;
         push_entry.has_second = 1'b1;
      end else begin
         push_entry.first_index = sat_index(first_index_ff, max_pos_in);
         push_entry.first_value = max_in;
         push_entry.second_index = sat_index(first_index_ff, min_pos_in);
         push_entry.second_value = min_in;
         push_entry.has_second = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= mmpd_pkg::COUNT_BITS'(2);
         pixel_count_ff <= mmpd_pkg::PIXEL_BITS'(1);
         first_index_ff <= '0;
         sample_ff <= '0;
         acc_ff <= '0;
         open_ff <= 1'b0;
      end else if (restart) begin
         unique case (csr_index)
            mmpd_pkg::CSR_POINT_COUNT: point_count_ff <= csr_data;
            mmpd_pkg::CSR_PIXEL_COUNT: pixel_count_ff <= csr_data[mmpd_pkg::PIXEL_BITS-1:0];
            mmpd_pkg::CSR_FIRST_INDEX: first_index_ff <= csr_data;
            default: ;
         endcase
         sample_ff <= '0;
         acc_ff <= '0;
         open_ff <= 1'b0;
      end else if (accept) begin
         sample_ff <= sample_in;
         if (decimate) begin
            acc_ff <= acc_in;
            open_ff <= open_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && decimate) begin
         min_ff <= min_in;
         max_ff <= max_in;
         min_pos_ff <= min_pos_in;
         max_pos_ff <= max_pos_in;
      end
   end

endmodule

@@ design/mmpd_queue.sv @@
module mmpd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  mmpd_pkg::entry_type push_entry,
   output logic                head_valid,
   input  logic                pop,
   output mmpd_pkg::entry_type head_entry
);

   mmpd_pkg::entry_type slot_ff [mmpd_pkg::QUEUE_DEPTH];
   logic [mmpd_pkg::QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [mmpd_pkg::QCNT_BITS-1:0] count_ff;
   logic                           full;
   logic                           push;

   assign full = count_ff == mmpd_pkg::QCNT_BITS'(mmpd_pkg::QUEUE_DEPTH);
   assign push_ready = !full;
   assign push = push_valid && push_ready;
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + mmpd_pkg::QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + mmpd_pkg::QPTR_BITS'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + mmpd_pkg::QCNT_BITS'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - mmpd_pkg::QCNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTH
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!push && !pop) |=> $stable(count_ff))
      else $error("queue count moved without push or pop");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mmpd_pkg::QCNT_BITS'(mmpd_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

@@ design/mmpd_back.sv @@
module mmpd_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    head_valid,
   input  mmpd_pkg::entry_type                     head_entry,
   output logic                                    pop,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [mmpd_pkg::INDEX_BITS-1:0]         rsp_point_index,
   output logic signed [mmpd_pkg::SAMPLE_BITS-1:0] rsp_point_value,
   output logic                                    rsp_last_of_run,
   output logic                                    rsp_end_of_window
);

   mmpd_pkg::phase_type phase_ff, phase_in;
   logic                                    valid_ff;
   logic [mmpd_pkg::INDEX_BITS-1:0]         index_ff, index_in;
   logic signed [mmpd_pkg::SAMPLE_BITS-1:0] value_ff, value_in;
   logic                                    last_ff, last_in;
   logic                                    end_ff, end_in;
   logic                                    load;

   assign load = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      phase_in = phase_ff;
      pop = 1'b0;
      index_in = head_entry.first_index;
      value_in = head_entry.first_value;
      last_in = 1'b1;
      end_in = head_entry.window_end;
      unique case (phase_ff)
         mmpd_pkg::PH_FIRST: begin
            if (head_entry.has_second) begin
               last_in = 1'b0;
               end_in = 1'b0;
               phase_in = mmpd_pkg::PH_SECOND;
            end else begin
               pop = load;
            end
         end
         mmpd_pkg::PH_SECOND: begin
            index_in = head_entry.second_index;
            value_in = head_entry.second_value;
            phase_in = mmpd_pkg::PH_FIRST;
            pop = load;
         end
         default: begin
            phase_in = mmpd_pkg::PH_FIRST;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mmpd_pkg::PH_FIRST;
         valid_ff <= 1'b0;
      end else if (load) begin
         phase_ff <= phase_in;
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff <= index_in;
         value_ff <= value_in;
         last_ff <= last_in;
         end_ff <= end_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_point_index = index_ff;
   assign rsp_point_value = value_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_end_of_window = end_ff;

`ifndef SYNTH
   a_second_has_head: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == mmpd_pkg::PH_SECOND) |-> head_valid)
      else $error("second point pending without a queued pair");
   a_first_of_pair: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> (phase_ff == mmpd_pkg::PH_SECOND))
      else $error("first point of a pair shown without its partner pending");
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && end_ff) |-> last_ff)
      else $error("window end on a point that is not last of its run");
`endif

endmodule

@@ design/min_max_plot_decimator_top.sv @@
// Min/max decimator for one visible window of waveform samples.
// Request channel (req_): one signed sample per request, point_count of
// them make one window. When the window holds more than twice as many
// samples as display columns, each column bucket yields two points, its
// minimum and maximum in index order, on the last sample of the bucket;
// otherwise each sample yields one point. Response channel (rsp_): one
// point per transfer, with last_of_run on the final point of a request and
// end_of_window on the final point of the window.
// Configuration (csr_): index 0 point_count, 1 pixel_count, 2 first_index;
// a write to one of these restarts the window. Write only while the block
// is idle. A request is taken every cycle while the four-entry point queue
// has room; each point a request yields is written into the queue, then
// loaded into the output register that drives rsp_valid. The output
// register drains one point per cycle while rsp_ready is high, so a
// bucket pair leaves as two transfers. When the receiver stalls, the
// queue fills and req_ready drops; nothing is lost. Synchronous reset
// restores point_count 2, pixel_count 1, first_index 0 and empties the queue.
module min_max_plot_decimator_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [mmpd_pkg::SAMPLE_BITS-1:0] req_sample_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [mmpd_pkg::INDEX_BITS-1:0]         rsp_point_index,
   output logic signed [mmpd_pkg::SAMPLE_BITS-1:0] rsp_point_value,
   output logic                                    rsp_last_of_run,
   output logic                                    rsp_end_of_window,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mmpd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mmpd_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   logic                push_valid;
   logic                push_ready;
   mmpd_pkg::entry_type push_entry;
   logic                head_valid;
   logic                pop;
   mmpd_pkg::entry_type head_entry;

   mmpd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry)
   );

   mmpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .head_valid (head_valid),
      .pop        (pop),
      .head_entry (head_entry)
   );

   mmpd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_point_index   (rsp_point_index),
      .rsp_point_value   (rsp_point_value),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_window (rsp_end_of_window)
   );

endmodule
